/* sv/tmbt_pkg.sv */
// Shared types and constants for the tic to measure/beat/tic tracker.
package tmbt_pkg;

  localparam logic [15:0] RESET_TICS_PER_BEAT     = 16'd24;
  localparam logic [7:0]  RESET_BEATS_PER_MEASURE = 8'd4;
  localparam logic [15:0] MEASURE_MAX             = 16'hFFFF;

  // Input opcodes
  localparam logic [1:0] OP_RESTART   = 2'd0;
  localparam logic [1:0] OP_ADVANCE   = 2'd1;
  localparam logic [1:0] OP_SIGNATURE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_STOP_POSITION = 2'd0;
  localparam logic [1:0] CFG_RESTART_TICS  = 2'd1;
  localparam logic [1:0] CFG_RESTART_BEATS = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] delta_tics;
    logic [7:0]  sig_beats;
    logic [15:0] sig_tics;
  } in_t;

  typedef struct packed {
    logic [15:0] out_measure;
    logic [7:0]  out_beat;
    logic [15:0] out_tic;
    logic        reached;
    logic        bad_signature;
  } out_t;

  // Command class decided by the front end
  typedef enum logic [2:0] {
    CMD_RESTART,
    CMD_ADVANCE,
    CMD_SIGNATURE,
    CMD_BAD_SIGNATURE,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [23:0] delta_tics;
    logic [7:0]  sig_beats;
    logic [15:0] sig_tics;
  } entry_t;

  typedef struct packed {
    logic [31:0] stop_position;
    logic [15:0] default_tics_per_beat;
    logic [7:0]  default_beats_per_measure;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP,
    ST_MUL,
    ST_DIV1,
    ST_SET2,
    ST_DIV2,
    ST_SET3,
    ST_DIV3,
    ST_FINISH,
    ST_REPORT
  } state_t;

endpackage

/* sv/tmbt_front.sv */
// Front end: accept input transactions and classify them into queue entries.
module tmbt_front import tmbt_pkg::*; (
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  output logic   push_valid,
  input  logic   push_ready,
  output entry_t push_data
);

  always_comb begin
    push_valid           = in_valid;
    in_ready             = push_ready;
    push_data.delta_tics = in_data.delta_tics;
    push_data.sig_beats  = in_data.sig_beats;
    push_data.sig_tics   = in_data.sig_tics;
    unique case (in_data.opcode)
      OP_RESTART:   push_data.cmd = CMD_RESTART;
      OP_ADVANCE:   push_data.cmd = CMD_ADVANCE;
      OP_SIGNATURE: begin
        // a signature with a zero field is flagged, not applied
        if (in_data.sig_beats == 8'd0 || in_data.sig_tics == 16'd0) begin
          push_data.cmd = CMD_BAD_SIGNATURE;
        end else begin
          push_data.cmd = CMD_SIGNATURE;
        end
      end
      default:      push_data.cmd = CMD_NOP;
    endcase
  end

endmodule

/* sv/tmbt_queue.sv */
// Small FIFO of classified commands between front end and back end.
module tmbt_queue import tmbt_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/tmbt_back.sv */
// Back end: position state, clipping, shared bit-serial divider and result register.
module tmbt_back import tmbt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  entry_t pop_data,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  state_t      state;
  state_t      state_next;

  logic [31:0] abs_position;
  logic [15:0] measure_count;
  logic [7:0]  beat_count;
  logic [15:0] tic_count;
  logic [15:0] tics_per_beat;
  logic [7:0]  beats_per_measure;
  logic        done_flag;
  logic        bad;

  logic [23:0] delta_r;
  logic [23:0] dclip;
  logic [24:0] q1;
  logic [15:0] t2;

  // divider registers
  logic [23:0] rem;
  logic [24:0] dq;
  logic [23:0] divisor;
  logic [4:0]  cnt;

  logic        out_load;
  logic        pop;

  // one restoring division step
  logic [24:0] part;
  logic [25:0] diff;
  logic        ge;
  logic [23:0] rem_step;
  logic [24:0] dq_step;

  logic [32:0] end_pos;
  logic        end_hit;
  logic        abs_hit;
  logic [8:0]  beat_sum;
  logic [25:0] msum;

  always_comb begin
    part     = {rem, dq[24]};
    diff     = {1'b0, part} - {2'b00, divisor};
    ge       = !diff[25];
    rem_step = ge ? diff[23:0] : part[23:0];
    dq_step  = {dq[23:0], ge};
    end_pos  = {1'b0, abs_position} + 33'(delta_r);
    end_hit  = (end_pos >= {1'b0, cfg.stop_position});
    abs_hit  = (abs_position >= cfg.stop_position);
    beat_sum = {1'b0, beat_count} + {1'b0, dq[7:0]};
    msum     = 26'(measure_count) + 26'(q1) + 26'(dq[8:0]);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_data.cmd == CMD_ADVANCE && !done_flag) begin
            state_next = ST_CLIP;
          end else begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_CLIP:   state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV1;
      ST_DIV1:   if (cnt == 5'd1) state_next = ST_SET2;
      ST_SET2:   state_next = ST_DIV2;
      ST_DIV2:   if (cnt == 5'd1) state_next = ST_SET3;
      ST_SET3:   state_next = ST_DIV3;
      ST_DIV3:   if (cnt == 5'd1) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_REPORT;
      ST_REPORT: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_ready = (state == ST_IDLE);
    out_load  = (state == ST_REPORT) && (!out_valid || out_ready);
  end

  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      abs_position      <= '0;
      measure_count     <= '0;
      beat_count        <= '0;
      tic_count         <= '0;
      tics_per_beat     <= RESET_TICS_PER_BEAT;
      beats_per_measure <= RESET_BEATS_PER_MEASURE;
      done_flag         <= 1'b0;
      bad               <= 1'b0;
    end else begin
      if (pop) begin
        bad <= 1'b0;
        case (pop_data.cmd)
          CMD_RESTART: begin
            abs_position      <= '0;
            measure_count     <= '0;
            beat_count        <= '0;
            tic_count         <= '0;
            tics_per_beat     <= (cfg.default_tics_per_beat == 16'd0) ?
                                 16'd1 : cfg.default_tics_per_beat;
            beats_per_measure <= (cfg.default_beats_per_measure == 8'd0) ?
                                 8'd1 : cfg.default_beats_per_measure;
            done_flag         <= 1'b0;
          end
          CMD_SIGNATURE: begin
            if (!done_flag) begin
              tics_per_beat     <= pop_data.sig_tics;
              beats_per_measure <= pop_data.sig_beats;
            end
          end
          CMD_BAD_SIGNATURE: bad <= !done_flag;
          default: ;
        endcase
      end
      if (state == ST_CLIP) begin
        // clip so the position stops at the target
        if (end_hit) begin
          abs_position <= abs_hit ? abs_position : cfg.stop_position;
        end else begin
          abs_position <= end_pos[31:0];
        end
      end
      if (state == ST_FINISH) begin
        measure_count <= (msum > 26'(MEASURE_MAX)) ? MEASURE_MAX : msum[15:0];
        beat_count    <= rem[7:0];
        tic_count     <= t2;
        done_flag     <= abs_hit;
      end
    end
  end

  // datapath and divider
  always_ff @(posedge clk) begin
    if (pop) begin
      delta_r <= pop_data.delta_tics;
    end
    case (state)
      ST_CLIP: begin
        if (end_hit) begin
          dclip <= abs_hit ? 24'd0 : 24'(cfg.stop_position - abs_position);
        end else begin
          dclip <= delta_r;
        end
      end
      ST_MUL: begin
        divisor <= 24'(tics_per_beat) * 24'(beats_per_measure);
        dq      <= 25'(tic_count) + 25'(dclip);
        rem     <= '0;
        cnt     <= 5'd25;
      end
      ST_DIV1, ST_DIV2, ST_DIV3: begin
        rem <= rem_step;
        dq  <= dq_step;
        cnt <= cnt - 1'b1;
      end
      ST_SET2: begin
        // remainder split into beats; quotient is below 256
        q1      <= dq;
        rem     <= {8'd0, rem[23:8]};
        dq      <= {rem[7:0], 17'd0};
        divisor <= {8'd0, tics_per_beat};
        cnt     <= 5'd8;
      end
      ST_SET3: begin
        t2      <= rem[15:0];
        rem     <= '0;
        dq      <= {beat_sum, 16'd0};
        divisor <= {16'd0, beats_per_measure};
        cnt     <= 5'd9;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_measure   <= measure_count;
      out_data.out_beat      <= beat_count;
      out_data.out_tic       <= tic_count;
      out_data.reached       <= done_flag;
      out_data.bad_signature <= bad;
    end
  end

endmodule

/* sv/tic_to_measure_beat_tic_core.sv */
// Top level of the tic to measure/beat/tic tracker.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data   (in_t)
//   out      output     out_valid / out_ready  out_data  (out_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An advance in the back end runs on the shared restoring divider, which
// retires one quotient bit a cycle over three divisions (25, 8 and 9
// bits). Restart, signature, unused opcodes and an advance once the
// target is reached go straight from idle to the report state. The queue
// registers each accepted transaction before the back end starts work on it.
// Reset (rst, synchronous) clears the queue, the position and the result
// register, and loads the default signature. The queue keeps accepting up
// to QUEUE_DEPTH transactions while the back end works or the result waits
// to be taken.
module tic_to_measure_beat_tic_core import tmbt_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t   cfg;
  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  // Configuration is always accepted; write it only while no transaction
  // is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_position             <= '0;
      cfg.default_tics_per_beat     <= RESET_TICS_PER_BEAT;
      cfg.default_beats_per_measure <= RESET_BEATS_PER_MEASURE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STOP_POSITION: cfg.stop_position             <= cfg_data;
        CFG_RESTART_TICS:  cfg.default_tics_per_beat     <= cfg_data[15:0];
        CFG_RESTART_BEATS: cfg.default_beats_per_measure <= cfg_data[7:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Front end: classify each input transaction.
  tmbt_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue between classification and execution.
  tmbt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: update the position and present one result per command.
  tmbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
